/* rtl/nts_pkg.sv */
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types and constants for the nearest trimmed segment goal search.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

  localparam int MAX_LINES_DEF  = 16;
  localparam int T_FRAC_DEF     = 16;

  localparam logic [15:0] TRIM_RESET = 16'd600;
  localparam logic [24:0] DIST_MAX   = 25'd23726566;

  localparam int COORD_W   = 24;
  localparam int GOAL_W    = 3 * COORD_W;
  localparam int SEG_W     = 4 * COORD_W;
  localparam int MUL_W     = 28;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SQ_ITERS  = PROD_W / 2;
  localparam int DIV_N_W   = 50;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_ANSWERED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADD_WR,
    S_Q_RD, S_Q_LATCH, S_SQ_DX, S_SQ_DY, S_L_INIT, S_L_STEP, S_K,
    S_MUL_DXK, S_DIVX_INIT, S_DIVX_STEP, S_VX,
    S_MUL_DYK, S_DIVY_INIT, S_DIVY_STEP, S_VY,
    S_MUL_VXVX, S_MUL_VYVY, S_MUL_APXVX, S_MUL_APYVY, S_N,
    S_T, S_FDIV_STEP, S_T_SET,
    S_MUL_VXT, S_MUL_VYT, S_R, S_MUL_RXRX, S_MUL_RYRY, S_S,
    S_D_INIT, S_D_STEP, S_G_RD, S_G_LATCH, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_ADD_RD, OP_ADD_CMP, OP_ADD_WR,
    OP_Q_RD, OP_Q_LATCH, OP_SQ_DX, OP_SQ_DY, OP_L_INIT, OP_SQRT_STEP, OP_K,
    OP_MUL_DXK, OP_MUL_DYK, OP_DIV_INIT, OP_DIV_STEP, OP_VX, OP_VY,
    OP_MUL_VXVX, OP_MUL_VYVY, OP_MUL_APXVX, OP_MUL_APYVY, OP_N,
    OP_T, OP_T_SET, OP_MUL_VXT, OP_MUL_VYT, OP_R,
    OP_MUL_RXRX, OP_MUL_RYRY, OP_S, OP_D_INIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   rd_best;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic last;
    logic match;
    logic lzero;
    logic tdiv;
    logic iter_done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/nts_ram.sv */
// ----------------------------------------------------------------------------
// nts_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/nts_ctrl.sv */
// ----------------------------------------------------------------------------
// nts_ctrl
// Sequencer that steps the datapath through table updates and line scans.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              command_i,
  input  wire logic              out_stall_i,
  input  wire nts_pkg::dp_stat_t stat_i,
  output nts_pkg::dp_cmd_t       cmd_o,
  output logic                   in_stall_o,
  output logic                   out_valid_o
);
  import nts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_QUERY) begin
            state_d = stat_i.cnt_zero ? S_OUT : S_Q_RD;
          end else begin
            state_d = stat_i.cnt_zero ? S_ADD_WR : S_ADD_RD;
          end
        end
      end
      S_ADD_RD:    state_d = S_ADD_CMP;
      S_ADD_CMP: begin
        if (stat_i.match) begin
          state_d = S_ADD_WR;
        end else if (stat_i.last) begin
          state_d = stat_i.full ? S_OUT : S_ADD_WR;
        end else begin
          state_d = S_ADD_RD;
        end
      end
      S_ADD_WR:    state_d = S_OUT;
      S_Q_RD:      state_d = S_Q_LATCH;
      S_Q_LATCH:   state_d = S_SQ_DX;
      S_SQ_DX:     state_d = S_SQ_DY;
      S_SQ_DY:     state_d = S_L_INIT;
      S_L_INIT:    state_d = S_L_STEP;
      S_L_STEP:    state_d = stat_i.iter_done ? S_K : S_L_STEP;
      S_K:         state_d = stat_i.lzero ? S_MUL_VXVX : S_MUL_DXK;
      S_MUL_DXK:   state_d = S_DIVX_INIT;
      S_DIVX_INIT: state_d = S_DIVX_STEP;
      S_DIVX_STEP: state_d = stat_i.iter_done ? S_VX : S_DIVX_STEP;
      S_VX:        state_d = S_MUL_DYK;
      S_MUL_DYK:   state_d = S_DIVY_INIT;
      S_DIVY_INIT: state_d = S_DIVY_STEP;
      S_DIVY_STEP: state_d = stat_i.iter_done ? S_VY : S_DIVY_STEP;
      S_VY:        state_d = S_MUL_VXVX;
      S_MUL_VXVX:  state_d = S_MUL_VYVY;
      S_MUL_VYVY:  state_d = S_MUL_APXVX;
      S_MUL_APXVX: state_d = S_MUL_APYVY;
      S_MUL_APYVY: state_d = S_N;
      S_N:         state_d = S_T;
      S_T:         state_d = stat_i.tdiv ? S_FDIV_STEP : S_MUL_VXT;
      S_FDIV_STEP: state_d = stat_i.iter_done ? S_T_SET : S_FDIV_STEP;
      S_T_SET:     state_d = S_MUL_VXT;
      S_MUL_VXT:   state_d = S_MUL_VYT;
      S_MUL_VYT:   state_d = S_R;
      S_R:         state_d = S_MUL_RXRX;
      S_MUL_RXRX:  state_d = S_MUL_RYRY;
      S_MUL_RYRY:  state_d = S_S;
      S_S:         state_d = stat_i.last ? S_D_INIT : S_Q_RD;
      S_D_INIT:    state_d = S_D_STEP;
      S_D_STEP:    state_d = stat_i.iter_done ? S_G_RD : S_D_STEP;
      S_G_RD:      state_d = S_G_LATCH;
      S_G_LATCH:   state_d = S_OUT;
      S_OUT:       state_d = out_stall_i ? S_OUT : S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op      = OP_NONE;
    cmd_o.rd_best = 1'b0;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
        end
      end
      S_ADD_RD:    cmd_o.op = OP_ADD_RD;
      S_ADD_CMP:   cmd_o.op = OP_ADD_CMP;
      S_ADD_WR:    cmd_o.op = OP_ADD_WR;
      S_Q_RD:      cmd_o.op = OP_Q_RD;
      S_Q_LATCH:   cmd_o.op = OP_Q_LATCH;
      S_SQ_DX:     cmd_o.op = OP_SQ_DX;
      S_SQ_DY:     cmd_o.op = OP_SQ_DY;
      S_L_INIT:    cmd_o.op = OP_L_INIT;
      S_L_STEP:    cmd_o.op = OP_SQRT_STEP;
      S_K:         cmd_o.op = OP_K;
      S_MUL_DXK:   cmd_o.op = OP_MUL_DXK;
      S_DIVX_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIVX_STEP: cmd_o.op = OP_DIV_STEP;
      S_VX:        cmd_o.op = OP_VX;
      S_MUL_DYK:   cmd_o.op = OP_MUL_DYK;
      S_DIVY_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIVY_STEP: cmd_o.op = OP_DIV_STEP;
      S_VY:        cmd_o.op = OP_VY;
      S_MUL_VXVX:  cmd_o.op = OP_MUL_VXVX;
      S_MUL_VYVY:  cmd_o.op = OP_MUL_VYVY;
      S_MUL_APXVX: cmd_o.op = OP_MUL_APXVX;
      S_MUL_APYVY: cmd_o.op = OP_MUL_APYVY;
      S_N:         cmd_o.op = OP_N;
      S_T:         cmd_o.op = OP_T;
      S_FDIV_STEP: cmd_o.op = OP_DIV_STEP;
      S_T_SET:     cmd_o.op = OP_T_SET;
      S_MUL_VXT:   cmd_o.op = OP_MUL_VXT;
      S_MUL_VYT:   cmd_o.op = OP_MUL_VYT;
      S_R:         cmd_o.op = OP_R;
      S_MUL_RXRX:  cmd_o.op = OP_MUL_RXRX;
      S_MUL_RYRY:  cmd_o.op = OP_MUL_RYRY;
      S_S:         cmd_o.op = OP_S;
      S_D_INIT:    cmd_o.op = OP_D_INIT;
      S_D_STEP:    cmd_o.op = OP_SQRT_STEP;
      S_G_RD: begin
        cmd_o.op      = OP_NONE;
        cmd_o.rd_best = 1'b1;
      end
      S_G_LATCH: begin
        cmd_o.op      = OP_NONE;
        cmd_o.rd_best = 1'b1;
      end
      S_OUT:       out_valid_o = 1'b1;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nts_dp.sv */
// ----------------------------------------------------------------------------
// nts_dp
// Line table, shared multiplier, square root and divider units, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_dp #(
  parameter int MAX_LINES   = nts_pkg::MAX_LINES_DEF,
  parameter int T_FRAC_BITS = nts_pkg::T_FRAC_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire nts_pkg::dp_cmd_t        cmd_i,
  output nts_pkg::dp_stat_t            stat_o,
  input  wire logic                    cfg_valid_i,
  input  wire logic [15:0]             cfg_end_trim_i,
  input  wire logic                    command_i,
  input  wire logic signed [23:0]      goal_x_i,
  input  wire logic signed [23:0]      goal_y_i,
  input  wire logic signed [23:0]      goal_z_i,
  input  wire logic signed [23:0]      start_x_i,
  input  wire logic signed [23:0]      start_y_i,
  input  wire logic signed [23:0]      end_x_i,
  input  wire logic signed [23:0]      end_y_i,
  input  wire logic signed [23:0]      pos_x_i,
  input  wire logic signed [23:0]      pos_y_i,
  input  wire logic signed [23:0]      pos_z_i,
  output logic [2:0]                   status_o,
  output logic signed [23:0]           chosen_x_o,
  output logic signed [23:0]           chosen_y_o,
  output logic signed [23:0]           chosen_z_o,
  output logic [24:0]                  nearest_distance_o
);
  import nts_pkg::*;

  localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W = $clog2(MAX_LINES + 1);
  localparam int TW    = T_FRAC_BITS + 2;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (T_FRAC_BITS - 1);

  logic [15:0]             trim_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        idx_q, wr_idx_q, bi_q;

  logic [GOAL_W-1:0]       goal_q;
  logic [SEG_W-1:0]        seg_q;
  logic signed [23:0]      px_q, py_q;

  logic signed [24:0]      dx_q, dy_q, apx_q, apy_q;
  logic [24:0]             len_q;
  logic signed [25:0]      k_q, vx_q, vy_q;
  logic signed [TW-1:0]    t_q;
  logic [52:0]             qq_q;
  logic signed [52:0]      n_q;
  logic signed [MUL_W-1:0] ox_q, rx_q, ry_q;
  logic signed [PROD_W-1:0] prod_q, acc_q;
  logic [PROD_W-1:0]       best_q;

  logic [PROD_W-1:0]       sv_q, sres_q, sbit_q;
  logic [53:0]             rem_q;
  logic [52:0]             den_q;
  logic [DIV_N_W-1:0]      num_q, quo_q;
  logic                    neg_q;
  logic [5:0]              cnt_q;

  logic [2:0]              res_status_q;
  logic signed [23:0]      res_x_q, res_y_q, res_z_q;
  logic [24:0]             res_d_q;

  logic [GOAL_W-1:0]       goal_rdata;
  logic [SEG_W-1:0]        seg_rdata;
  logic [IDX_W-1:0]        raddr;
  logic                    ram_we;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d, sum_w, rnd_h, rnd_v;
  logic                     mul_en;
  logic [PROD_W:0]          s_rb;
  logic                     s_ge;
  logic [53:0]              d_r2;
  logic                     d_ge;
  logic signed [PROD_W-1:0] prod_mag;
  logic signed [53:0]       n_ext, q_ext;
  logic                     last;

  logic signed [24:0] sx_w, sy_w, ex_w, ey_w;

  assign raddr  = cmd_i.rd_best ? bi_q : idx_q;
  assign ram_we = (cmd_i.op == OP_ADD_WR);

  nts_ram #(.WIDTH(GOAL_W), .DEPTH(MAX_LINES)) u_goal_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (goal_q),
    .raddr_i (raddr),
    .rdata_o (goal_rdata)
  );

  nts_ram #(.WIDTH(SEG_W), .DEPTH(MAX_LINES)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (seg_q),
    .raddr_i (raddr),
    .rdata_o (seg_rdata)
  );

  assign sx_w = 25'(signed'(seg_rdata[4*COORD_W-1:3*COORD_W]));
  assign sy_w = 25'(signed'(seg_rdata[3*COORD_W-1:2*COORD_W]));
  assign ex_w = 25'(signed'(seg_rdata[2*COORD_W-1:COORD_W]));
  assign ey_w = 25'(signed'(seg_rdata[COORD_W-1:0]));

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_SQ_DX:     begin mul_a = MUL_W'(dx_q);  mul_b = MUL_W'(dx_q); end
      OP_SQ_DY:     begin mul_a = MUL_W'(dy_q);  mul_b = MUL_W'(dy_q); end
      OP_MUL_DXK:   begin mul_a = MUL_W'(dx_q);  mul_b = MUL_W'(k_q);  end
      OP_MUL_DYK:   begin mul_a = MUL_W'(dy_q);  mul_b = MUL_W'(k_q);  end
      OP_MUL_VXVX:  begin mul_a = MUL_W'(vx_q);  mul_b = MUL_W'(vx_q); end
      OP_MUL_VYVY:  begin mul_a = MUL_W'(vy_q);  mul_b = MUL_W'(vy_q); end
      OP_MUL_APXVX: begin mul_a = MUL_W'(apx_q); mul_b = MUL_W'(vx_q); end
      OP_MUL_APYVY: begin mul_a = MUL_W'(apy_q); mul_b = MUL_W'(vy_q); end
      OP_MUL_VXT:   begin mul_a = MUL_W'(vx_q);  mul_b = MUL_W'(t_q);  end
      OP_MUL_VYT:   begin mul_a = MUL_W'(vy_q);  mul_b = MUL_W'(t_q);  end
      OP_MUL_RXRX:  begin mul_a = rx_q;          mul_b = rx_q;         end
      OP_MUL_RYRY:  begin mul_a = ry_q;          mul_b = ry_q;         end
      default:      mul_en = 1'b0;
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign sum_w    = acc_q + prod_q;
  assign rnd_h    = prod_q + HALF;
  assign rnd_v    = rnd_h >>> T_FRAC_BITS;
  assign prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;

  assign s_rb = {1'b0, sres_q} + {1'b0, sbit_q};
  assign s_ge = {1'b0, sv_q} >= s_rb;

  assign d_r2 = {rem_q[52:0], num_q[DIV_N_W-1]};
  assign d_ge = d_r2 >= {1'b0, den_q};

  assign n_ext = 54'(n_q);
  assign q_ext = signed'({1'b0, qq_q});
  assign last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  always_comb begin
    stat_o.cnt_zero  = (count_q == '0);
    stat_o.full      = (count_q == CNT_W'(MAX_LINES));
    stat_o.last      = last;
    stat_o.match     = (goal_rdata == goal_q);
    stat_o.lzero     = (sres_q == '0);
    stat_o.tdiv      = (qq_q != '0) && (n_ext > 0) && (n_ext < q_ext);
    stat_o.iter_done = (cnt_q == 6'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q  <= TRIM_RESET;
      count_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        trim_q <= cfg_end_trim_i;
      end
      if (ram_we && (res_status_q == ST_ADDED)) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    case (cmd_i.op)
      OP_CAPTURE: begin
        goal_q   <= {goal_x_i, goal_y_i, goal_z_i};
        seg_q    <= {start_x_i, start_y_i, end_x_i, end_y_i};
        px_q     <= pos_x_i;
        py_q     <= pos_y_i;
        idx_q    <= '0;
        wr_idx_q <= IDX_W'(count_q);
        res_d_q  <= '0;
        if (command_i == CMD_QUERY) begin
          res_status_q <= (count_q == '0) ? ST_EMPTY : ST_ANSWERED;
          res_x_q      <= pos_x_i;
          res_y_q      <= pos_y_i;
          res_z_q      <= pos_z_i;
        end else begin
          res_status_q <= ST_ADDED;
          res_x_q      <= '0;
          res_y_q      <= '0;
          res_z_q      <= '0;
        end
      end
      OP_ADD_CMP: begin
        if (goal_rdata == goal_q) begin
          wr_idx_q     <= idx_q;
          res_status_q <= ST_REPLACED;
        end else if (last) begin
          if (count_q == CNT_W'(MAX_LINES)) begin
            res_status_q <= ST_DROPPED;
          end
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      OP_Q_LATCH: begin
        dx_q  <= ex_w - sx_w;
        dy_q  <= ey_w - sy_w;
        apx_q <= 25'(px_q) - sx_w;
        apy_q <= 25'(py_q) - sy_w;
      end
      OP_SQ_DY:     acc_q <= prod_q;
      OP_L_INIT: begin
        sv_q   <= sum_w;
        sres_q <= '0;
        sbit_q <= PROD_W'(1) << (PROD_W - 2);
        cnt_q  <= 6'(SQ_ITERS);
      end
      OP_D_INIT: begin
        sv_q   <= best_q;
        sres_q <= '0;
        sbit_q <= PROD_W'(1) << (PROD_W - 2);
        cnt_q  <= 6'(SQ_ITERS);
      end
      OP_SQRT_STEP: begin
        if (s_ge) begin
          sv_q   <= sv_q - s_rb[PROD_W-1:0];
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          res_d_q <= DIST_MAX;
          if (((sres_q >> 1) + (s_ge ? sbit_q : '0)) <= PROD_W'(DIST_MAX)) begin
            res_d_q <= 25'((sres_q >> 1) + (s_ge ? sbit_q : '0));
          end
        end
      end
      OP_K: begin
        len_q <= sres_q[24:0];
        k_q   <= signed'({1'b0, sres_q[24:0]}) - signed'({10'd0, trim_q});
        if (sres_q == '0) begin
          vx_q <= '0;
          vy_q <= '0;
        end
      end
      OP_DIV_INIT: begin
        neg_q <= prod_q[PROD_W-1];
        num_q <= prod_mag[DIV_N_W-1:0];
        rem_q <= '0;
        den_q <= 53'(len_q);
        quo_q <= '0;
        cnt_q <= 6'(DIV_N_W);
      end
      OP_DIV_STEP: begin
        rem_q <= d_ge ? (d_r2 - {1'b0, den_q}) : d_r2;
        quo_q <= {quo_q[DIV_N_W-2:0], d_ge};
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 6'd1;
      end
      OP_VX:        vx_q <= neg_q ? -26'(quo_q) : 26'(quo_q);
      OP_VY:        vy_q <= neg_q ? -26'(quo_q) : 26'(quo_q);
      OP_MUL_VYVY:  acc_q <= prod_q;
      OP_MUL_APXVX: qq_q  <= 53'(sum_w);
      OP_MUL_APYVY: acc_q <= prod_q;
      OP_N:         n_q   <= 53'(sum_w);
      OP_T: begin
        if ((qq_q == '0) || (n_ext <= 0)) begin
          t_q <= '0;
        end else if (n_ext >= q_ext) begin
          t_q <= TW'(1) <<< T_FRAC_BITS;
        end else begin
          rem_q <= {1'b0, n_q};
          num_q <= '0;
          den_q <= qq_q;
          quo_q <= '0;
          cnt_q <= 6'(T_FRAC_BITS);
        end
      end
      OP_T_SET:     t_q  <= TW'(quo_q);
      OP_MUL_VYT:   ox_q <= MUL_W'(rnd_v);
      OP_R: begin
        rx_q <= MUL_W'(apx_q) - ox_q;
        ry_q <= MUL_W'(apy_q) - MUL_W'(rnd_v);
      end
      OP_MUL_RYRY:  acc_q <= prod_q;
      OP_S: begin
        if ((idx_q == '0) || (PROD_W'(sum_w) < best_q)) begin
          best_q <= PROD_W'(sum_w);
          bi_q   <= idx_q;
        end
        if (!last) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.rd_best && (cmd_i.op == OP_NONE) && (raddr == bi_q)) begin
      res_x_q <= signed'(goal_rdata[3*COORD_W-1:2*COORD_W]);
      res_y_q <= signed'(goal_rdata[2*COORD_W-1:COORD_W]);
      res_z_q <= signed'(goal_rdata[COORD_W-1:0]);
    end
  end

  assign status_o           = res_status_q;
  assign chosen_x_o         = res_x_q;
  assign chosen_y_o         = res_y_q;
  assign chosen_z_o         = res_z_q;
  assign nearest_distance_o = res_d_q;

endmodule

`default_nettype wire

/* rtl/nearest_trimmed_segment_goal.sv */
// ----------------------------------------------------------------------------
// nearest_trimmed_segment_goal
// Routing line table with a nearest trimmed segment search over stored lines.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               word
//  in       input      in_valid_i/in_stall_o   command, goal, segment, position
//  out      output     out_valid_o/out_stall_i status, chosen goal, distance
//  cfg      input      cfg_valid_i/cfg_ready_o end_trim
//
// An add scans the stored lines for a matching goal, then writes the line or,
// with a full table, drops it. A query runs each stored line through the square
// root unit and the 50-step divider, adds the fraction divide when it runs and
// skips the divides for a zero-length line, then ends with a 28-step square root.
// Reset clears the line count and loads end_trim with 600. One word is in
// work at a time; a result waits in the output register while out_stall_i
// is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_trimmed_segment_goal #(
  parameter int MAX_LINES   = nts_pkg::MAX_LINES_DEF,
  parameter int T_FRAC_BITS = nts_pkg::T_FRAC_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire logic signed [23:0] goal_x_i,
  input  wire logic signed [23:0] goal_y_i,
  input  wire logic signed [23:0] goal_z_i,
  input  wire logic signed [23:0] start_x_i,
  input  wire logic signed [23:0] start_y_i,
  input  wire logic signed [23:0] end_x_i,
  input  wire logic signed [23:0] end_y_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [23:0] pos_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic signed [23:0]      chosen_x_o,
  output logic signed [23:0]      chosen_y_o,
  output logic signed [23:0]      chosen_z_o,
  output logic [24:0]             nearest_distance_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_end_trim_i
);
  import nts_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  nts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  nts_dp #(
    .MAX_LINES   (MAX_LINES),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .stat_o             (dp_stat),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_end_trim_i     (cfg_end_trim_i),
    .command_i          (command_i),
    .goal_x_i           (goal_x_i),
    .goal_y_i           (goal_y_i),
    .goal_z_i           (goal_z_i),
    .start_x_i          (start_x_i),
    .start_y_i          (start_y_i),
    .end_x_i            (end_x_i),
    .end_y_i            (end_y_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .pos_z_i            (pos_z_i),
    .status_o           (status_o),
    .chosen_x_o         (chosen_x_o),
    .chosen_y_o         (chosen_y_o),
    .chosen_z_o         (chosen_z_o),
    .nearest_distance_o (nearest_distance_o)
  );

endmodule

`default_nettype wire
